/* src/arcq_pkg.sv */
package arcq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int PAYLOAD_BYTES_DEF = 16;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_NACK   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [3:0] EV_STAGED    = 4'd0;
    localparam logic [3:0] EV_QUEUED    = 4'd1;
    localparam logic [3:0] EV_DROP_FULL = 4'd2;
    localparam logic [3:0] EV_DROP_OVF  = 4'd3;
    localparam logic [3:0] EV_FRAME     = 4'd4;
    localparam logic [3:0] EV_REMOVED   = 4'd5;
    localparam logic [3:0] EV_UNMATCHED = 4'd6;
    localparam logic [3:0] EV_GAVE_UP   = 4'd7;
    localparam logic [3:0] EV_IDLE      = 4'd8;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] node_id;
        logic [7:0] command_code;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } cmd_in_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] node_id_res;
        logic [7:0] command_code_res;
        logic [7:0] frame_byte;
        logic       frame_byte_valid;
        logic [3:0] retry_number;
        logic       last_res;
    } cmd_res_t;

    // controller -> datapath
    typedef struct packed {
        logic       latch_in;     // capture input word, submit staging
        logic       enqueue;      // write tail entry, start copy
        logic       copy_step;    // move one staged byte into ring
        logic       tick;         // advance clock
        logic       bump_retry;   // increment head retry count
        logic       pop;          // advance head
        logic       send_begin;   // stamp head, clear byte pointer
        logic       send_step;    // advance byte pointer
        logic       clear_stage;
        logic       emit;         // drive a result
        logic [3:0] emit_event;
        logic       emit_last;
    } arcq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] operation;
        logic       last;
        logic       overflow;
        logic       full;
        logic       empty;
        logic       one_left;     // count is one (before pop)
        logic       was_empty;    // count was zero before enqueue
        logic       match;
        logic       timeout;
        logic       can_retry;
        logic       copy_done;
        logic       send_last;
    } arcq_sts_t;

endpackage

/* src/arcq_datapath.sv */
module arcq_datapath
    import arcq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_in_t   in_word,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data,
    input  arcq_ctl_t ctl,
    output arcq_sts_t sts,
    output cmd_res_t  result,
    output logic      result_strobe
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW = $clog2(PAYLOAD_BYTES);
    localparam int LW = $clog2(PAYLOAD_BYTES + 1);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = QW + PW;
    localparam logic [QW-1:0] QMAX = QW'(QUEUE_DEPTH - 1);

    logic [7:0]    target_mem [QUEUE_DEPTH];
    logic [7:0]    code_mem   [QUEUE_DEPTH];
    logic [LW-1:0] len_mem    [QUEUE_DEPTH];
    logic [31:0]   stamp_mem  [QUEUE_DEPTH];
    logic [3:0]    retry_mem  [QUEUE_DEPTH];
    logic [7:0]    payload_mem [QUEUE_DEPTH * PAYLOAD_BYTES];
    logic [7:0]    stage_mem  [PAYLOAD_BYTES];

    logic [QW-1:0] head_reg, tail_reg, copy_slot_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   now_reg;
    logic [LW-1:0] stage_len_reg;
    logic          stage_ovf_reg;
    logic [15:0]   timeout_reg;
    logic [3:0]    limit_reg;
    cmd_in_t       in_reg;
    logic [LW-1:0] copy_ptr_reg, send_ptr_reg;
    logic          was_empty_reg;
    logic [7:0]    pay_rd_reg;

    logic [QW-1:0] head_inc, tail_inc;
    logic [LW-1:0] head_len;
    logic [31:0]   elapsed;

    assign head_inc = (head_reg == QMAX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == QMAX) ? '0 : tail_reg + 1'b1;
    assign head_len = len_mem[head_reg];
    // the tick advances the clock at the end of the decide cycle; compare with the new value
    assign elapsed  = (now_reg + 32'd1) - stamp_mem[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            now_reg       <= '0;
            stage_len_reg <= '0;
            stage_ovf_reg <= 1'b0;
            timeout_reg   <= 16'd1000;
            limit_reg     <= 4'd3;
            copy_ptr_reg  <= '0;
            send_ptr_reg  <= '0;
            copy_slot_reg <= '0;
            was_empty_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[3:0];
            end
            if (ctl.latch_in && in_word.operation == OP_SUBMIT && in_word.byte_valid)
            begin
                if (stage_len_reg < LW'(PAYLOAD_BYTES))
                    stage_len_reg <= stage_len_reg + 1'b1;
                else
                    stage_ovf_reg <= 1'b1;
            end
            if (ctl.enqueue)
            begin
                tail_reg      <= tail_inc;
                count_reg     <= count_reg + 1'b1;
                was_empty_reg <= (count_reg == '0);
                copy_slot_reg <= tail_reg;
                copy_ptr_reg  <= '0;
            end
            if (ctl.copy_step)
                copy_ptr_reg <= copy_ptr_reg + 1'b1;
            if (ctl.clear_stage)
            begin
                stage_len_reg <= '0;
                stage_ovf_reg <= 1'b0;
            end
            if (ctl.tick)
                now_reg <= now_reg + 1'b1;
            if (ctl.pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            if (ctl.send_begin)
                send_ptr_reg <= '0;
            else if (ctl.send_step)
                send_ptr_reg <= send_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            in_reg <= in_word;
            if (in_word.operation == OP_SUBMIT && in_word.byte_valid
                && stage_len_reg < LW'(PAYLOAD_BYTES))
                stage_mem[stage_len_reg[PW-1:0]] <= in_word.payload_byte;
        end
        if (ctl.enqueue)
        begin
            target_mem[tail_reg] <= in_reg.node_id;
            code_mem[tail_reg]   <= in_reg.command_code;
            len_mem[tail_reg]    <= stage_len_reg;
            stamp_mem[tail_reg]  <= now_reg;
            retry_mem[tail_reg]  <= 4'd0;
        end
        if (ctl.copy_step)
            payload_mem[MW'(copy_slot_reg) * MW'(PAYLOAD_BYTES) + MW'(copy_ptr_reg)]
                <= stage_mem[copy_ptr_reg[PW-1:0]];
        if (ctl.bump_retry)
            retry_mem[head_reg] <= retry_mem[head_reg] + 1'b1;
        if (ctl.send_begin)
            stamp_mem[head_reg] <= now_reg;
        pay_rd_reg <= payload_mem[MW'(head_reg) * MW'(PAYLOAD_BYTES)
                                  + MW'(ctl.send_begin ? '0 : send_ptr_reg + 1'b1)];
    end

    always_comb
    begin
        sts.operation = in_reg.operation;
        sts.last      = in_reg.last;
        sts.overflow  = stage_ovf_reg;
        sts.full      = (count_reg >= CW'(QUEUE_DEPTH));
        sts.empty     = (count_reg == '0);
        sts.one_left  = (count_reg == CW'(1));
        sts.was_empty = was_empty_reg;
        sts.match     = (target_mem[head_reg] == in_reg.node_id);
        sts.timeout   = (elapsed > {16'd0, timeout_reg});
        sts.can_retry = (retry_mem[head_reg] < limit_reg);
        sts.copy_done = (copy_ptr_reg >= len_mem[copy_slot_reg]);
        sts.send_last = (head_len == '0) || (send_ptr_reg + 1'b1 >= head_len);
    end

    always_comb
    begin
        result = '0;
        result.event_res = ctl.emit_event;
        result.last_res  = ctl.emit_last;
        case (ctl.emit_event)
            EV_QUEUED, EV_DROP_FULL, EV_DROP_OVF:
            begin
                result.node_id_res      = in_reg.node_id;
                result.command_code_res = in_reg.command_code;
            end
            EV_UNMATCHED:
                result.node_id_res = in_reg.node_id;
            EV_REMOVED, EV_GAVE_UP:
                result.node_id_res = target_mem[head_reg];
            EV_FRAME:
            begin
                result.node_id_res      = target_mem[head_reg];
                result.command_code_res = code_mem[head_reg];
                result.retry_number     = retry_mem[head_reg];
                if (head_len != '0)
                begin
                    result.frame_byte       = pay_rd_reg;
                    result.frame_byte_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign result_strobe = ctl.emit;

endmodule

/* src/arcq_control.sv */
module arcq_control
    import arcq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  arcq_sts_t sts,
    output arcq_ctl_t ctl
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_COPY   = 3'd2;
    localparam logic [2:0] S_PREP   = 3'd3;
    localparam logic [2:0] S_SEND   = 3'd4;
    localparam logic [2:0] S_POP    = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.emit      = 1'b1;
                ctl.emit_last = 1'b1;
                state_next    = S_IDLE;
                case (sts.operation)
                    OP_SUBMIT:
                        if (!sts.last)
                            ctl.emit_event = EV_STAGED;
                        else if (sts.overflow)
                        begin
                            ctl.emit_event  = EV_DROP_OVF;
                            ctl.clear_stage = 1'b1;
                        end
                        else if (sts.full)
                        begin
                            ctl.emit_event  = EV_DROP_FULL;
                            ctl.clear_stage = 1'b1;
                        end
                        else
                        begin
                            // hold result until the copy is done
                            ctl.emit    = 1'b0;
                            ctl.enqueue = 1'b1;
                            state_next  = S_COPY;
                        end
                    OP_ACK, OP_NACK:
                        if (!sts.empty && sts.match)
                        begin
                            ctl.emit       = 1'b0;
                            state_next     = S_POP;
                            ctl.emit_event = EV_REMOVED;
                        end
                        else
                            ctl.emit_event = EV_UNMATCHED;
                    default:
                    begin
                        ctl.tick = 1'b1;
                        ctl.emit_event = EV_IDLE;
                        if (!sts.empty && sts.timeout)
                        begin
                            ctl.emit      = 1'b0;
                            ctl.emit_last = 1'b0;
                            if (sts.can_retry)
                            begin
                                ctl.bump_retry = 1'b1;
                                state_next     = S_PREP;
                            end
                            else
                                state_next = S_POP;
                        end
                    end
                endcase
            end
            S_COPY:
            begin
                if (sts.copy_done)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_event  = EV_QUEUED;
                    ctl.clear_stage = 1'b1;
                    ctl.emit_last   = !sts.was_empty;
                    state_next      = sts.was_empty ? S_PREP : S_IDLE;
                end
                else
                    ctl.copy_step = 1'b1;
            end
            S_POP:
            begin
                ctl.emit       = 1'b1;
                ctl.emit_event = (sts.operation == OP_TICK) ? EV_GAVE_UP : EV_REMOVED;
                ctl.emit_last  = sts.one_left;
                ctl.pop        = 1'b1;
                state_next     = sts.one_left ? S_IDLE : S_PREP;
            end
            S_PREP:
            begin
                ctl.send_begin = 1'b1;
                state_next     = S_SEND;
            end
            S_SEND:
            begin
                ctl.emit       = 1'b1;
                ctl.emit_event = EV_FRAME;
                ctl.emit_last  = sts.send_last;
                ctl.send_step  = 1'b1;
                if (sts.send_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* src/ack_retry_command_queue_core.sv */
// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+--------------------------
// command   | in        | start / busy       | cmd (cmd_in_t)
// result    | out       | result_valid strobe| res (cmd_res_t)
// config    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Staged, dropped, unmatched and idle commands end in the decide state; an enqueue
// copies each staged byte into the ring before the queued word, a pop adds a step, and
// a frame send adds a prep step plus one word per payload byte (one if none).
// rst_n clears pointers, count, clock and staging; ring contents stay unknown.
// Result words are strobed once; the receiver cannot stall them.
module ack_retry_command_queue_core
    import arcq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_in_t     cmd,
    output logic        result_valid,
    output cmd_res_t    res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    arcq_ctl_t ctl;
    arcq_sts_t sts;

    assign cfg_ready = 1'b1;

    arcq_control u_control
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    arcq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_word       (cmd),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ctl           (ctl),
        .sts           (sts),
        .result        (res),
        .result_strobe (result_valid)
    );

endmodule

/* tb/arcq_checker.sv */
module arcq_checker
    import arcq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_in_t     cmd,
    input  logic        result_valid,
    input  cmd_res_t    res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fails,
    output int          pending
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int PBYTES = PAYLOAD_BYTES_DEF;

    logic [7:0]  ring_target [DEPTH];
    logic [7:0]  ring_code   [DEPTH];
    logic [4:0]  ring_len    [DEPTH];
    logic [31:0] ring_stamp  [DEPTH];
    logic [3:0]  ring_tries  [DEPTH];
    logic [7:0]  ring_bytes  [DEPTH][PBYTES];
    logic [2:0]  head, tail;
    logic [3:0]  count;
    logic [31:0] now_ms;
    logic [7:0]  stage [PBYTES];
    logic [4:0]  stage_len;
    logic        stage_ovf;
    logic [15:0] timeout_ms;
    logic [3:0]  retry_limit;

    cmd_res_t expected_words[$];
    int       words_this_cmd;

    assign pending = expected_words.size();

    function automatic void add_word(logic [3:0] ev, logic [7:0] node, logic [7:0] code,
                                     logic [7:0] b, logic bv, logic [3:0] tries);
        cmd_res_t w;
        w.event_res        = ev;
        w.node_id_res      = node;
        w.command_code_res = code;
        w.frame_byte       = b;
        w.frame_byte_valid = bv;
        w.retry_number     = tries;
        w.last_res         = 1'b0;
        expected_words.push_back(w);
        words_this_cmd++;
    endfunction

    function automatic void send_frame();
        ring_stamp[head] = now_ms;
        if (ring_len[head] == 0)
            add_word(EV_FRAME, ring_target[head], ring_code[head], 8'd0, 1'b0, ring_tries[head]);
        for (int i = 0; i < ring_len[head]; i++)
            add_word(EV_FRAME, ring_target[head], ring_code[head], ring_bytes[head][i], 1'b1,
                     ring_tries[head]);
    endfunction

    function automatic void pop_head(logic [3:0] ev);
        add_word(ev, ring_target[head], 8'd0, 8'd0, 1'b0, 4'd0);
        head  = head + 3'd1;
        count = count - 4'd1;
        if (count != 0)
            send_frame();
    endfunction

    function automatic void predict_cmd(cmd_in_t c);
        words_this_cmd = 0;
        case (c.operation)
            OP_SUBMIT:
            begin
                if (c.byte_valid) begin
                    if (stage_len < PBYTES) begin
                        stage[stage_len[3:0]] = c.payload_byte;
                        stage_len = stage_len + 5'd1;
                    end else
                        stage_ovf = 1'b1;
                end
                if (!c.last)
                    add_word(EV_STAGED, 8'd0, 8'd0, 8'd0, 1'b0, 4'd0);
                else if (stage_ovf || count >= DEPTH) begin
                    add_word(stage_ovf ? EV_DROP_OVF : EV_DROP_FULL, c.node_id, c.command_code,
                             8'd0, 1'b0, 4'd0);
                    stage_len = '0;
                    stage_ovf = 1'b0;
                end else begin
                    ring_target[tail] = c.node_id;
                    ring_code[tail]   = c.command_code;
                    ring_len[tail]    = stage_len;
                    for (int i = 0; i < stage_len; i++)
                        ring_bytes[tail][i] = stage[i];
                    ring_stamp[tail] = now_ms;
                    ring_tries[tail] = 4'd0;
                    tail  = tail + 3'd1;
                    count = count + 4'd1;
                    stage_len = '0;
                    stage_ovf = 1'b0;
                    add_word(EV_QUEUED, c.node_id, c.command_code, 8'd0, 1'b0, 4'd0);
                    if (count == 1)
                        send_frame();
                end
            end
            OP_ACK, OP_NACK:
            begin
                if (count != 0 && ring_target[head] == c.node_id)
                    pop_head(EV_REMOVED);
                else
                    add_word(EV_UNMATCHED, c.node_id, 8'd0, 8'd0, 1'b0, 4'd0);
            end
            default:
            begin
                now_ms = now_ms + 32'd1;
                if (count != 0 && (now_ms - ring_stamp[head]) > {16'd0, timeout_ms}) begin
                    if (ring_tries[head] < retry_limit) begin
                        ring_tries[head] = ring_tries[head] + 4'd1;
                        send_frame();
                    end else
                        pop_head(EV_GAVE_UP);
                end else
                    add_word(EV_IDLE, 8'd0, 8'd0, 8'd0, 1'b0, 4'd0);
            end
        endcase
        if (words_this_cmd > 0)
            expected_words[expected_words.size() - 1].last_res = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cmd_res_t want;
        if (!rst_n) begin
            head = '0;
            tail = '0;
            count = '0;
            now_ms = '0;
            stage_len = '0;
            stage_ovf = 1'b0;
            timeout_ms = 16'd1000;
            retry_limit = 4'd3;
            fails = 0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_ms = cfg_data;
                else
                    retry_limit = cfg_data[3:0];
            end
            if (start && !busy)
                predict_cmd(cmd);
            if (result_valid) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word %h", res);
                end else begin
                    want = expected_words.pop_front();
                    if (res.event_res != want.event_res
                        || res.node_id_res != want.node_id_res
                        || res.command_code_res != want.command_code_res
                        || res.frame_byte != want.frame_byte
                        || res.frame_byte_valid != want.frame_byte_valid
                        || res.retry_number != want.retry_number
                        || res.last_res != want.last_res) begin
                        fails++;
                        if (fails <= 10)
                            $display("result mismatch: expected %h got %h", want, res);
                    end
                end
            end
        end
    end

endmodule

/* tb/tb.sv */
module tb;
    import arcq_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_in_t     cmd;
    logic        result_valid;
    cmd_res_t    res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          fails;
    int          pending;
    int          idle_pct;
    int          stall_cycles;

    ack_retry_command_queue_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .res(res), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    arcq_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .res(res), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog: restart on any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic drive_word(cmd_in_t c);
        int gap;
        if ($urandom_range(99, 0) < idle_pct) begin
            start = 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        cmd = c;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic drive_op(logic [1:0] op, logic [7:0] node);
        cmd_in_t c;
        c = '0;
        c.operation = op;
        c.node_id = node;
        c.command_code = 8'($urandom_range(255, 0));
        c.payload_byte = 8'($urandom_range(255, 0));
        c.byte_valid = 1'($urandom_range(1, 0));
        c.last = 1'($urandom_range(1, 0));
        drive_word(c);
    endtask

    // one command: len payload words, an empty payload is a single closing word
    task automatic drive_command(logic [7:0] node, logic [7:0] code, int len, bit extremes);
        cmd_in_t c;
        int n;
        n = (len == 0) ? 1 : len;
        for (int i = 0; i < n; i++) begin
            if (!extremes && $urandom_range(19, 0) == 0) begin
                c = '0;
                c.operation = OP_SUBMIT;
                c.node_id = 8'($urandom_range(255, 0));
                c.payload_byte = 8'($urandom_range(255, 0));
                drive_word(c);
            end
            c.operation = OP_SUBMIT;
            c.node_id = node;
            c.command_code = code;
            c.payload_byte = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255, 0));
            c.byte_valid = (len != 0);
            c.last = (i == n - 1);
            drive_word(c);
        end
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        while (pending != 0)
            @(negedge clk);
        start = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(int items, int ack_pct);
        int sent;
        int pick;
        int len;
        logic [7:0] node;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99, 0);
            node = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0))
                                               : 8'($urandom_range(3, 0));
            if (pick < ack_pct) begin
                drive_op($urandom_range(1, 0) ? OP_ACK : OP_NACK, node);
                sent++;
            end else if (pick < 60) begin
                drive_op(OP_TICK, node);
                sent++;
            end else begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(17, 15)
                                                  : $urandom_range(4, 0);
                drive_command(node, 8'($urandom_range(255, 0)), len, 1'b0);
                sent += (len == 0) ? 1 : len;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        idle_pct = 0;
        stall_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_RETRY, 16'd15);
        drive_op(OP_TICK, 8'd0);
        drive_op(OP_ACK, 8'd5);
        drive_command(8'd0, 8'd0, 0, 1'b1);
        drive_op(OP_TICK, 8'd0);
        drive_op(OP_NACK, 8'd9);
        drive_op(OP_ACK, 8'd0);
        drive_command(8'd255, 8'd255, 16, 1'b1);
        drive_op(OP_NACK, 8'd255);

        write_reg(CFG_TIMEOUT, 16'd1);
        write_reg(CFG_RETRY, 16'd0);
        idle_pct = 30;
        random_phase(100, 10);

        write_reg(CFG_TIMEOUT, 16'd5);
        write_reg(CFG_RETRY, 16'd15);
        idle_pct = 47;
        random_phase(100, 5);

        write_reg(CFG_TIMEOUT, 16'd2);
        write_reg(CFG_RETRY, 16'd1);
        idle_pct = 0;
        random_phase(100, 25);

        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
